// ===== hdl/sonar_frame_receiver_macros.svh =====
// assertion macros shared by the receiver
`ifndef SONAR_FRAME_RECEIVER_MACROS_SVH
`define SONAR_FRAME_RECEIVER_MACROS_SVH

// same-cycle implication, checked out of reset
`define SFR_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define SFR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/sfr_pkg.sv =====
`default_nettype none
package sfr_pkg;

  localparam int unsigned MAX_PAYLOAD = 1024;
  localparam int unsigned POS_W       = $clog2(MAX_PAYLOAD + 1);
  localparam int unsigned DIST_BYTES  = 4;

  localparam logic [7:0]  START_B = 8'h42;
  localparam logic [7:0]  START_R = 8'h52;
  localparam logic [15:0] DIST_ID = 16'h04BB;

  localparam logic [1:0] STATUS_GOOD    = 2'd0;
  localparam logic [1:0] STATUS_BAD_SUM = 2'd1;
  localparam logic [1:0] STATUS_TOO_BIG = 2'd2;

  typedef struct packed {
    logic       vld;
    logic [7:0] data;
  } sfr_beat_t;

  typedef struct packed {
    logic        vld;
    logic [1:0]  frame_status;
    logic [15:0] message_id;
    logic        is_distance_simple;
    logic [31:0] distance_mm;
    logic [7:0]  confidence;
  } sfr_result_t;

endpackage
`default_nettype wire

// ===== hdl/sfr_if.sv =====
`default_nettype none
interface sfr_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface sfr_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  frame_status;
  logic [15:0] message_id;
  logic        is_distance_simple;
  logic [31:0] distance_mm;
  logic [7:0]  confidence;

  modport source (
    output valid, output frame_status, output message_id,
    output is_distance_simple, output distance_mm, output confidence,
    input ready
  );
  modport sink (
    input valid, input frame_status, input message_id,
    input is_distance_simple, input distance_mm, input confidence,
    output ready
  );
endinterface
`default_nettype wire

// ===== hdl/sfr_in_reg.sv =====
`default_nettype none
module sfr_in_reg (
  input  wire logic              clk,
  input  wire logic              rst_n,
  sfr_in_if.sink                 in_ch,
  input  wire logic              take,
  output sfr_pkg::sfr_beat_t     beat
);
  import sfr_pkg::*;

  logic       vld_r;
  logic       vld_nxt;
  logic [7:0] data_r;
  logic       load;

  assign in_ch.ready = !vld_r || take;
  assign load        = in_ch.valid && in_ch.ready;

  always_comb begin
    vld_nxt = vld_r;
    if (load) begin
      vld_nxt = 1'b1;
    end else if (take) begin
      vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= in_ch.rx_byte;
    end
  end

  assign beat.vld  = vld_r;
  assign beat.data = data_r;

endmodule
`default_nettype wire

// ===== hdl/sfr_parser.sv =====
`default_nettype none
module sfr_parser (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire sfr_pkg::sfr_beat_t beat,
  input  wire logic               out_free,
  output logic                    take,
  output sfr_pkg::sfr_result_t    res
);
  import sfr_pkg::*;

  typedef enum logic [3:0] {
    PH_HUNT, PH_R, PH_LEN_LO, PH_LEN_HI, PH_ID_LO, PH_ID_HI,
    PH_SRC, PH_DST, PH_PAYLOAD, PH_CK_LO, PH_CK_HI
  } phase_t;

  phase_t           phase_r, phase_nxt;
  logic [POS_W-1:0] pos_r, pos_nxt;
  logic [POS_W-1:0] len_r, len_nxt;
  logic [7:0]       len_lo_r, len_lo_nxt;
  logic [15:0]      sum_r, sum_nxt;
  logic [7:0]       ck_lo_r, ck_lo_nxt;
  logic [15:0]      id_r, id_nxt;
  logic [31:0]      dist_r, dist_nxt;
  logic [7:0]       conf_r, conf_nxt;

  logic [7:0]       b;
  logic [15:0]      sum_add;
  logic [15:0]      full_len;
  logic [POS_W-1:0] pos_inc;
  logic             start_c;
  logic             emit_c;
  logic             fields_c;
  logic [1:0]       status_c;
  logic             dist_c;

  assign b        = beat.data;
  assign sum_add  = sum_r + {8'h00, b};
  assign full_len = {b, len_lo_r};
  assign pos_inc  = pos_r + POS_W'(1);

  always_comb begin
    phase_nxt  = phase_r;
    pos_nxt    = pos_r;
    len_nxt    = len_r;
    len_lo_nxt = len_lo_r;
    sum_nxt    = sum_r;
    ck_lo_nxt  = ck_lo_r;
    id_nxt     = id_r;
    dist_nxt   = dist_r;
    conf_nxt   = conf_r;
    start_c    = 1'b0;
    emit_c     = 1'b0;
    fields_c   = 1'b0;
    status_c   = STATUS_GOOD;
    case (phase_r)
      PH_HUNT: begin
        start_c = (b == START_B);
      end
      PH_R: begin
        if (b == START_R) begin
          sum_nxt   = sum_add;
          phase_nxt = PH_LEN_LO;
        end else if (b == START_B) begin
          start_c = 1'b1;
        end else begin
          phase_nxt = PH_HUNT;
        end
      end
      PH_LEN_LO: begin
        len_lo_nxt = b;
        sum_nxt    = sum_add;
        phase_nxt  = PH_LEN_HI;
      end
      PH_LEN_HI: begin
        sum_nxt = sum_add;
        if (full_len > 16'(MAX_PAYLOAD)) begin
          phase_nxt = PH_HUNT;
          emit_c    = 1'b1;
          status_c  = STATUS_TOO_BIG;
        end else begin
          len_nxt   = full_len[POS_W-1:0];
          phase_nxt = PH_ID_LO;
        end
      end
      PH_ID_LO: begin
        id_nxt    = {8'h00, b};
        sum_nxt   = sum_add;
        phase_nxt = PH_ID_HI;
      end
      PH_ID_HI: begin
        id_nxt    = {b, id_r[7:0]};
        sum_nxt   = sum_add;
        phase_nxt = PH_SRC;
      end
      PH_SRC: begin
        sum_nxt   = sum_add;
        phase_nxt = PH_DST;
      end
      PH_DST: begin
        sum_nxt   = sum_add;
        pos_nxt   = '0;
        phase_nxt = (len_r == '0) ? PH_CK_LO : PH_PAYLOAD;
      end
      PH_PAYLOAD: begin
        sum_nxt = sum_add;
        if (pos_r < POS_W'(DIST_BYTES)) begin
          case (pos_r[1:0])
            2'd0:    dist_nxt[7:0]   = b;
            2'd1:    dist_nxt[15:8]  = b;
            2'd2:    dist_nxt[23:16] = b;
            default: dist_nxt[31:24] = b;
          endcase
        end
        conf_nxt = b;
        pos_nxt  = pos_inc;
        if (pos_inc >= len_r) begin
          phase_nxt = PH_CK_LO;
        end
      end
      PH_CK_LO: begin
        ck_lo_nxt = b;
        phase_nxt = PH_CK_HI;
      end
      PH_CK_HI: begin
        phase_nxt = PH_HUNT;
        emit_c    = 1'b1;
        fields_c  = 1'b1;
        status_c  = ({b, ck_lo_r} == sum_r) ? STATUS_GOOD : STATUS_BAD_SUM;
      end
      default: begin
        phase_nxt = PH_HUNT;
      end
    endcase
    // a start byte seen while hunting or in PH_R opens a fresh frame
    if (start_c) begin
      phase_nxt = PH_R;
      sum_nxt   = {8'h00, START_B};
      pos_nxt   = '0;
      len_nxt   = '0;
      ck_lo_nxt = '0;
      id_nxt    = '0;
      dist_nxt  = '0;
      conf_nxt  = '0;
    end
  end

  assign take   = beat.vld && (!emit_c || out_free);
  assign dist_c = fields_c && (id_r == DIST_ID);

  assign res.vld                = beat.vld && emit_c;
  assign res.frame_status       = status_c;
  assign res.message_id         = fields_c ? id_r : 16'h0000;
  assign res.is_distance_simple = dist_c;
  assign res.distance_mm        = dist_c ? dist_r : 32'h0000_0000;
  assign res.confidence         = dist_c ? conf_r : 8'h00;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_HUNT;
      pos_r    <= '0;
      len_r    <= '0;
      len_lo_r <= '0;
      sum_r    <= '0;
      ck_lo_r  <= '0;
      id_r     <= '0;
      dist_r   <= '0;
      conf_r   <= '0;
    end else if (take) begin
      phase_r  <= phase_nxt;
      pos_r    <= pos_nxt;
      len_r    <= len_nxt;
      len_lo_r <= len_lo_nxt;
      sum_r    <= sum_nxt;
      ck_lo_r  <= ck_lo_nxt;
      id_r     <= id_nxt;
      dist_r   <= dist_nxt;
      conf_r   <= conf_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== hdl/sfr_out_reg.sv =====
`default_nettype none
module sfr_out_reg (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire sfr_pkg::sfr_result_t res,
  output logic                      out_free,
  sfr_out_if.source                 out_ch
);
  import sfr_pkg::*;

  logic        vld_r;
  logic        vld_nxt;
  sfr_result_t data_r;
  logic        load;

  assign out_free = !vld_r || out_ch.ready;
  assign load     = res.vld && out_free;

  always_comb begin
    vld_nxt = vld_r;
    if (out_free) begin
      vld_nxt = res.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= res;
    end
  end

  assign out_ch.valid              = vld_r;
  assign out_ch.frame_status       = data_r.frame_status;
  assign out_ch.message_id         = data_r.message_id;
  assign out_ch.is_distance_simple = data_r.is_distance_simple;
  assign out_ch.distance_mm        = data_r.distance_mm;
  assign out_ch.confidence         = data_r.confidence;

endmodule
`default_nettype wire

// ===== hdl/sonar_frame_receiver.sv =====
// channel   direction  beat contents
// in_ch     input      rx_byte
// out_ch    output     frame_status, message_id, is_distance_simple,
//                      distance_mm, confidence
//
// one byte per cycle sustained unless out_ch stalls on a frame-closing byte
// input register, one parser state update, output register
// rst_n is synchronous: parser back to hunting, both registers empty
// a stalled out_ch only holds the parser on a byte that closes a frame
`default_nettype none
`include "sonar_frame_receiver_macros.svh"
module sonar_frame_receiver (
  input wire logic clk,
  input wire logic rst_n,
  sfr_in_if.sink   in_ch,
  sfr_out_if.source out_ch
);
  import sfr_pkg::*;

  sfr_beat_t   beat;
  sfr_result_t res;
  logic        take;
  logic        out_free;

  sfr_in_reg u_in_reg (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .take  (take),
    .beat  (beat)
  );

  sfr_parser u_parser (
    .clk      (clk),
    .rst_n    (rst_n),
    .beat     (beat),
    .out_free (out_free),
    .take     (take),
    .res      (res)
  );

  sfr_out_reg u_out_reg (
    .clk      (clk),
    .rst_n    (rst_n),
    .res      (res),
    .out_free (out_free),
    .out_ch   (out_ch)
  );

  `SFR_ASSERT_NOW(a_dist_flag, out_ch.valid,
    out_ch.is_distance_simple == (out_ch.message_id == DIST_ID),
    "distance flag disagrees with message id")
  `SFR_ASSERT_NOW(a_too_big_clear, out_ch.valid && out_ch.frame_status == STATUS_TOO_BIG,
    out_ch.message_id == 16'h0000 && out_ch.distance_mm == 32'h0000_0000,
    "oversize frame result carries fields")
  `SFR_ASSERT_NOW(a_no_stall_loss, res.vld && !out_free, !take,
    "result dropped while output stage full")
  `SFR_ASSERT_NEXT(a_take_loads, res.vld && take, out_ch.valid,
    "result not loaded into output stage")

endmodule
`default_nettype wire
